### rtl/podo_pkg.sv
// shared constants and helper functions for the planar odometry core
`timescale 1ns / 1ps
package podo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  // register indexes on the configuration port
  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_OPS     = 3'd1;
  localparam logic [2:0] REG_VELINT  = 3'd2;
  localparam logic [2:0] REG_HAS_X   = 3'd3;
  localparam logic [2:0] REG_HAS_Y   = 3'd4;
  localparam logic [2:0] REG_HAS_YAW = 3'd5;

  localparam logic CMD_SET_ORIGIN = 1'b1;

  // angles in q16.16 degrees
  localparam logic signed [27:0] DEG360   = 28'sd23592960;
  localparam logic signed [27:0] DEG180   = 28'sd11796480;
  localparam logic signed [27:0] DEG90    = 28'sd5898240;

  // one turn is 45 * 2^19; ceil(2^20 / 45) gives an exact quotient for 16-bit values
  localparam logic [15:0] TURN_UNITS = 16'd45;
  localparam logic [30:0] TURN_RECIP = 31'd23302;

  // cordic gain compensation in q2.30
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -70'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // atan(2^-i) in q16.16 degrees
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] r;
    unique case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/podo_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module podo_mul
  import podo_pkg::*;
(
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  output logic signed [67:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### rtl/podo_cordic.sv
// iterative sine/cosine unit: angle reduction by reciprocal multiply, then cordic rotations
`timescale 1ns / 1ps
module podo_cordic
  import podo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [34:0] angle,
  output logic signed [33:0] sin_out,
  output logic signed [33:0] cos_out,
  output logic               done
);

  typedef enum logic [1:0] {C_IDLE, C_RED, C_FOLD, C_ITER} cstate_t;

  cstate_t            state;
  logic [34:0]        mag;
  logic               aneg;
  logic [STEP_W-1:0]  i;
  logic signed [33:0] x, y;
  logic signed [27:0] z;
  logic               fneg;

  logic [15:0]        hi, hrem;
  logic [30:0]        qprod;
  logic [10:0]        quo;
  logic [34:0]        red;
  logic signed [27:0] r0, r1, r2;
  logic               fold_neg;
  logic signed [33:0] x_n, y_n;
  logic signed [27:0] z_n, at;

  always_comb begin
    // magnitude mod one turn: whole 2^19 units mod 45, low bits pass through
    hi    = mag[34:19];
    qprod = 31'(hi) * TURN_RECIP;
    quo   = qprod[30:20];
    hrem  = hi - 16'(quo) * TURN_UNITS;
    red   = {10'd0, hrem[5:0], mag[18:0]};
    // remainder takes the sign of the angle, then wrap and fold to +-90
    r0 = 28'(mag[26:0]);
    if (aneg) r0 = -r0;
    r1 = r0;
    if (r1 >= DEG180) r1 = r1 - DEG360;
    if (r1 < -DEG180) r1 = r1 + DEG360;
    r2 = r1;
    fold_neg = 1'b0;
    if (r1 > DEG90) begin
      r2 = r1 - DEG180;
      fold_neg = 1'b1;
    end else if (r1 < -DEG90) begin
      r2 = r1 + DEG180;
      fold_neg = 1'b1;
    end
    at = 28'(atan_deg(5'(i)));
    if (z >= 0) begin
      x_n = x - (y >>> i);
      y_n = y + (x >>> i);
      z_n = z - at;
    end else begin
      x_n = x + (y >>> i);
      y_n = y - (x >>> i);
      z_n = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            mag   <= angle[34] ? 35'(-angle) : 35'(angle);
            aneg  <= angle[34];
            state <= C_RED;
          end
        end
        C_RED: begin
          mag   <= red;
          state <= C_FOLD;
        end
        C_FOLD: begin
          z     <= r2;
          fneg  <= fold_neg;
          x     <= CORDIC_K;
          y     <= '0;
          i     <= '0;
          state <= C_ITER;
        end
        C_ITER: begin
          x <= x_n;
          y <= y_n;
          z <= z_n;
          i <= i + 1'b1;
          if (i == STEP_W'(CORDIC_STEPS - 1)) begin
            sin_out <= fneg ? -y_n : y_n;
            cos_out <= fneg ? -x_n : x_n;
            done    <= 1'b1;
            state   <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("cordic done held longer than one cycle");

endmodule

### rtl/planar_odometry_integrator_core.sv
// Planar odometry core: an update request makes two passes through the 16-step iterative
// cordic (displacement by mean heading, velocity by new heading) and shares the single
// 34x34 multiplier between states; set-origin, ops-mode, disabled and zero-step requests go
// straight from dispatch to the output. Only one request is in flight; s_tready is low until
// its result has been taken on the master side.
`timescale 1ns / 1ps
module planar_odometry_integrator_core
  import podo_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // step_time[15:0], body_vx, body_vy, body_wz, pos_x_reading, pos_y_reading,
  // heading_reading (32 bits each, from bit 16 up)
  input  logic [207:0] s_tdata,
  input  logic         s_tuser,  // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  // pose_x, pose_y, pose_yaw, world_vx, world_vy, out_wz (32 bits each)
  output logic [191:0] m_tdata,
  output logic         m_tuser,  // updated
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic         cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_MX, ST_MY, ST_MW, ST_HD, ST_CW,
    ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_OUT
  } state_t;

  state_t state;

  logic r_en, r_ops, r_velint, r_hx, r_hy, r_hyaw;
  logic signed [31:0] pose_x, pose_y, pose_yaw, origin_x, origin_y, origin_yaw;
  logic signed [31:0] prev_pos_x, prev_pos_y, prev_heading, prev_vx, prev_vy, prev_wz;
  logic signed [31:0] wvx, wvy;
  logic               updated;

  logic               in_cmd;
  logic [15:0]        in_dt;
  logic signed [31:0] in_vx, in_vy, in_wz, in_rx, in_ry, in_rh;

  logic signed [31:0] dx, dy, rot_a, rot_b, gx;
  logic signed [69:0] acc;
  logic               phase;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;

  logic               c_start, c_done;
  logic signed [34:0] c_angle;
  logic signed [33:0] c_sin, c_cos;

  logic signed [67:0] trap_r;
  logic signed [31:0] trap_sat, disp_sel, prev_next, yaw_sel;
  logic signed [35:0] mean36;
  logic signed [69:0] rsum;
  logic signed [31:0] rres;

  podo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  podo_cordic u_cordic (
    .clk(clk), .rst(rst), .start(c_start), .angle(c_angle),
    .sin_out(c_sin), .cos_out(c_cos), .done(c_done)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MX: begin mul_a = 34'(in_vx) + 34'(prev_vx); mul_b = 34'(in_dt); end
      ST_MY: begin mul_a = 34'(in_vy) + 34'(prev_vy); mul_b = 34'(in_dt); end
      ST_MW: begin mul_a = 34'(in_wz) + 34'(prev_wz); mul_b = 34'(in_dt); end
      ST_R1: begin mul_a = 34'(rot_a); mul_b = c_cos; end
      ST_R2: begin mul_a = 34'(rot_b); mul_b = c_sin; end
      ST_R3: begin mul_a = 34'(rot_a); mul_b = c_sin; end
      ST_R4: begin mul_a = 34'(rot_b); mul_b = c_cos; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase

    // trapezoid rounded to nearest, ties up
    trap_r   = (mul_p + 68'sd65536) >>> 17;
    trap_sat = sat32(70'(trap_r));
    disp_sel = '0;
    prev_next = '0;
    if (state == ST_MY) begin
      if (r_hx || !r_velint) begin
        disp_sel  = sat32(70'(in_rx) - 70'(prev_pos_x));
        prev_next = in_rx;
      end else begin
        disp_sel  = trap_sat;
        prev_next = sat32(70'(prev_pos_x) + 70'(trap_sat));
      end
    end else begin
      if (r_hy || !r_velint) begin
        disp_sel  = sat32(70'(in_ry) - 70'(prev_pos_y));
        prev_next = in_ry;
      end else begin
        disp_sel  = trap_sat;
        prev_next = sat32(70'(prev_pos_y) + 70'(trap_sat));
      end
    end
    yaw_sel = (r_hyaw || !r_velint) ? in_rh
                                    : sat32(70'(prev_heading) + 70'(trap_r));
    mean36  = ((36'(yaw_sel) + 36'(prev_heading)) >>> 1) - 36'(origin_yaw);

    rsum = (state == ST_R3) ? acc - 70'(mul_p) : acc + 70'(mul_p);
    rres = sat32((rsum + 70'sd536870912) >>> 30);

    c_start = 1'b0;
    c_angle = '0;
    if (state == ST_HD) begin
      c_start = 1'b1;
      c_angle = 35'(mean36);
    end else if (state == ST_R5 && !phase) begin
      c_start = 1'b1;
      c_angle = 35'(pose_yaw);
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {prev_wz, wvy, wvx, pose_yaw, pose_y, pose_x};
  assign m_tuser  = updated;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      {r_en, r_ops, r_velint, r_hx, r_hy, r_hyaw} <= '0;
      {pose_x, pose_y, pose_yaw, origin_x, origin_y, origin_yaw} <= '0;
      {prev_pos_x, prev_pos_y, prev_heading, prev_vx, prev_vy, prev_wz} <= '0;
      {wvx, wvy} <= '0;
      updated <= 1'b0;
      phase   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_ENABLE:  r_en     <= cfg_wdata;
          REG_OPS:     r_ops    <= cfg_wdata;
          REG_VELINT:  r_velint <= cfg_wdata;
          REG_HAS_X:   r_hx     <= cfg_wdata;
          REG_HAS_Y:   r_hy     <= cfg_wdata;
          REG_HAS_YAW: r_hyaw   <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_cmd <= s_tuser;
            in_dt  <= s_tdata[15:0];
            in_vx  <= s_tdata[47:16];
            in_vy  <= s_tdata[79:48];
            in_wz  <= s_tdata[111:80];
            in_rx  <= s_tdata[143:112];
            in_ry  <= s_tdata[175:144];
            in_rh  <= s_tdata[207:176];
            state  <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          updated <= 1'b0;
          state   <= ST_OUT;
          if (in_cmd == CMD_SET_ORIGIN) begin
            if (!r_ops) begin
              origin_x   <= sat32(70'(origin_x) + 70'(pose_x));
              origin_y   <= sat32(70'(origin_y) + 70'(pose_y));
              origin_yaw <= sat32(70'(origin_yaw) + 70'(pose_yaw));
              pose_x     <= '0;
              pose_y     <= '0;
              pose_yaw   <= '0;
              wvx        <= prev_vx;
              wvy        <= prev_vy;
              updated    <= 1'b1;
            end
          end else if (r_en && in_dt != 16'd0) begin
            updated <= 1'b1;
            if (r_ops) begin
              pose_x   <= in_rx;
              pose_y   <= in_ry;
              pose_yaw <= in_rh;
            end else begin
              state <= ST_MX;
            end
          end
        end
        ST_MX: state <= ST_MY;
        ST_MY: begin
          dx         <= disp_sel;
          prev_pos_x <= prev_next;
          state      <= ST_MW;
        end
        ST_MW: begin
          dy         <= disp_sel;
          prev_pos_y <= prev_next;
          state      <= ST_HD;
        end
        ST_HD: begin
          prev_heading <= yaw_sel;
          pose_yaw     <= sat32(70'(yaw_sel) - 70'(origin_yaw));
          prev_vx      <= in_vx;
          prev_vy      <= in_vy;
          prev_wz      <= in_wz;
          rot_a        <= dx;
          rot_b        <= dy;
          phase        <= 1'b0;
          state        <= ST_CW;
        end
        ST_CW: if (c_done) state <= ST_R1;
        ST_R1: state <= ST_R2;
        ST_R2: begin
          acc   <= 70'(mul_p);
          state <= ST_R3;
        end
        ST_R3: begin
          gx    <= rres;
          state <= ST_R4;
        end
        ST_R4: begin
          acc   <= 70'(mul_p);
          state <= ST_R5;
        end
        ST_R5: begin
          if (!phase) begin
            // displacement rotated to world; now rotate velocity by new heading
            pose_x <= sat32(70'(pose_x) + 70'(gx));
            pose_y <= sat32(70'(pose_y) + 70'(rres));
            rot_a  <= in_vx;
            rot_b  <= in_vy;
            phase  <= 1'b1;
            state  <= ST_CW;
          end else begin
            wvx   <= gx;
            wvy   <= rres;
            state <= ST_OUT;
          end
        end
        ST_OUT: if (m_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input and output sides open at once");

  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in flight");

  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tready) |=> s_tready)
    else $error("block did not return to idle after result taken");

  assert property (@(posedge clk) disable iff (rst) c_done |-> (state == ST_CW))
    else $error("cordic finished outside its wait state");

endmodule
